@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the design files
// Each macro checks one property on the rising clock edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in every cycle
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/txcon_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console package
// Screen defaults, cell codes, operation codes and stream field widths.
// ----------------------------------------------------------------------------
package txcon_pkg;

    // Default screen geometry
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    // Cell layout: character in the low byte, attribute in the high byte
    localparam int            CELL_W       = 16;
    localparam logic [7:0]    TEXT_ATTR    = 8'h0F;
    localparam logic [7:0]    CH_SPACE     = 8'h20;
    localparam logic [7:0]    CH_BACKSPACE = 8'h08;
    localparam logic [7:0]    CH_NEWLINE   = 8'h0A;
    localparam logic [15:0]   BLANK_CELL   = {TEXT_ATTR, CH_SPACE};

    // Operation codes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SETC  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Field widths
    localparam int OPC_W  = 2;
    localparam int CHAR_W = 8;
    localparam int PCOL_W = 7;
    localparam int PROW_W = 5;
    localparam int OFF_W  = 11;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 40;

endpackage

@@ design/txcon_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module txcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/text_console_cursor_engine.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine
// Character-cell screen store with cursor, put-char, scroll, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_tvalid/s_tready with the operation in
//   s_tuser and the character and position in s_tdata. Every transaction
//   returns exactly one result on m_tvalid/m_tready: the cursor after the
//   operation, its linear offset, and for a read the cell contents.
//   Every cell pass goes through the single write port of the screen RAM,
//   one cell per cycle; scrolling reads one row down and writes in the
//   cycle after, then blanks the bottom row.
//   s_tready is high only while the engine is idle, one transaction at a time.
//   After reset a clearing pass blanks the whole screen before the first
//   transaction is taken; the cursor starts at the origin.
//   A result waits in the output register while m_tready is low; the next
//   transaction is taken meanwhile, but its result is held back until the
//   waiting one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_cursor_engine #(
    parameter int SCREEN_COLUMNS = txcon_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = txcon_pkg::SCREEN_ROWS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // char_code[7:0], pos_col[14:8], pos_row[19:15], zero fill [23:20]
    input  logic [txcon_pkg::IN_W-1:0]   s_tdata,
    // opcode[1:0]
    input  logic [txcon_pkg::OPC_W-1:0]  s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
    // cell_char[30:23], cell_attr[38:31], zero fill [39]
    output logic [txcon_pkg::OUT_W-1:0]  m_tdata
);

    localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELLS - SCREEN_COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WRITE,
        S_SCROLL,
        S_FILL,
        S_READ,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t                       state_reg, state_next;
    logic [COL_W-1:0]             col_reg, col_next;
    logic [ROW_W-1:0]             row_reg, row_next;
    logic [ADDR_W-1:0]            cnt_reg, cnt_next;
    logic                         adv_reg, adv_next;
    logic [txcon_pkg::CELL_W-1:0] wcell_reg, wcell_next;
    logic [COL_W-1:0]             rcol_reg, rcol_next;
    logic [ROW_W-1:0]             rrow_reg, rrow_next;
    logic [7:0]                   rchar_reg, rchar_next;
    logic [7:0]                   rattr_reg, rattr_next;
    logic                         mvalid_reg, mvalid_next;
    logic [txcon_pkg::OUT_W-1:0]  mdata_reg, mdata_next;

    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [txcon_pkg::CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [txcon_pkg::CELL_W-1:0] ram_rdata;

    logic [ADDR_W-1:0]            cur_off;
    logic [ADDR_W-1:0]            rd_off;
    logic [ADDR_W-1:0]            cnt_prev;
    logic                         in_fire;
    logic [7:0]                   in_char;
    logic [txcon_pkg::PCOL_W-1:0] in_col;
    logic [txcon_pkg::PROW_W-1:0] in_row;
    logic [COL_W-1:0]             in_col_clamp;
    logic [ROW_W-1:0]             in_row_clamp;

    // Unpack the input transaction
    assign in_char = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[19:15];
    assign in_fire = s_tvalid && s_tready;

    // Clamp requested position to the screen
    assign in_col_clamp = (32'(in_col) >= 32'(SCREEN_COLUMNS)) ? LAST_COL : COL_W'(in_col);
    assign in_row_clamp = (32'(in_row) >= 32'(SCREEN_ROWS))    ? LAST_ROW : ROW_W'(in_row);

    // Linear offsets of the cursor and of the read position
    assign cur_off  = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign rd_off   = ADDR_W'(rrow_reg) * COLS_A + ADDR_W'(rcol_reg);
    assign cnt_prev = cnt_reg - ADDR_W'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // Screen store
    txcon_ram #(
        .WIDTH (txcon_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Drive the RAM ports from the sequencer state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = txcon_pkg::BLANK_CELL;
        ram_raddr = cnt_reg + COLS_A;
        case (state_reg)
            S_INIT, S_FILL:
            begin
                ram_we = 1'b1;
            end
            S_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_off;
                ram_wdata = wcell_reg;
            end
            S_SCROLL:
            begin
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_prev;
                ram_wdata = ram_rdata;
            end
            S_READ:
            begin
                ram_raddr = rd_off;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        adv_next    = adv_reg;
        wcell_next  = wcell_reg;
        rcol_next   = rcol_reg;
        rrow_next   = rrow_reg;
        rchar_next  = rchar_reg;
        rattr_next  = rattr_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        // Drop the result once the receiver takes it
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rchar_next = '0;
                    rattr_next = '0;
                    adv_next   = 1'b0;
                    state_next = S_DONE;
                    case (s_tuser)
                        txcon_pkg::OP_PUT:
                        begin
                            if (in_char == txcon_pkg::CH_BACKSPACE)
                            begin
                                // Step back and blank that cell; nothing at origin
                                if (col_reg != '0)
                                begin
                                    col_next   = col_reg - COL_W'(1);
                                    wcell_next = txcon_pkg::BLANK_CELL;
                                    state_next = S_WRITE;
                                end
                                else if (row_reg != '0)
                                begin
                                    col_next   = LAST_COL;
                                    row_next   = row_reg - ROW_W'(1);
                                    wcell_next = txcon_pkg::BLANK_CELL;
                                    state_next = S_WRITE;
                                end
                            end
                            else if (in_char == txcon_pkg::CH_NEWLINE)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                            else
                            begin
                                wcell_next = {txcon_pkg::TEXT_ATTR, in_char};
                                adv_next   = 1'b1;
                                state_next = S_WRITE;
                            end
                        end
                        txcon_pkg::OP_SETC:
                        begin
                            col_next = in_col_clamp;
                            row_next = in_row_clamp;
                        end
                        txcon_pkg::OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = S_FILL;
                        end
                        txcon_pkg::OP_READ:
                        begin
                            rcol_next  = in_col_clamp;
                            rrow_next  = in_row_clamp;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                // Advance after a printable character, wrapping at line end
                state_next = S_DONE;
                if (adv_reg)
                begin
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            cnt_next   = '0;
                            state_next = S_SCROLL;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            S_SCROLL:
            begin
                // Read one row down, write it in the next cycle, then blank bottom row
                if (cnt_reg == BOTTOM_ROW)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_FILL:
            begin
                if (cnt_reg == LAST_CELL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            S_READ:
            begin
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT:
            begin
                rchar_next = ram_rdata[7:0];
                rattr_next = ram_rdata[15:8];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Load the result once the output register is free
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, rattr_reg, rchar_reg,
                                   txcon_pkg::OFF_W'(cur_off),
                                   txcon_pkg::PROW_W'(row_reg),
                                   txcon_pkg::PCOL_W'(col_reg)};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            col_reg    <= '0;
            row_reg    <= '0;
            cnt_reg    <= '0;
            adv_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            cnt_reg    <= cnt_next;
            adv_reg    <= adv_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        wcell_reg <= wcell_next;
        rcol_reg  <= rcol_next;
        rrow_reg  <= rrow_next;
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
        mdata_reg <= mdata_next;
    end

    // Cursor never leaves the screen
    `CHK_ALWAYS(a_cursor_on_screen,
        (32'(col_reg) < SCREEN_COLUMNS) && (32'(row_reg) < SCREEN_ROWS),
        "cursor outside the screen")

    // Captured read data follows a read request
    `CHK_SAME(a_read_after_req, state_reg == S_READ_WAIT,
        $past(state_reg) == S_READ, "read data captured without a read")

    // Scroll copy hands over to blanking the bottom row
    `CHK_NEXT(a_scroll_to_fill, (state_reg == S_SCROLL) && (cnt_reg == BOTTOM_ROW),
        (state_reg == S_FILL) && (cnt_reg == BOTTOM_ROW), "scroll did not blank bottom row")

    // A new result is loaded only from the done state
    `CHK_SAME(a_result_from_done, $rose(mvalid_reg),
        $past(state_reg) == S_DONE, "result loaded outside done state")

endmodule

@@ dv/text_console_cursor_engine_tb.sv @@
// ----------------------------------------------------------------------------
// Text console cursor engine testbench
// Drives put-char, set-cursor, clear and read transactions into the console.
// Each result is checked field by field against its fixed table value or an
// in-bench model of the screen store and cursor. A directed table covers the
// origin, the screen edges, clamping, scrolling and clearing. Random cursor moves
// followed by bursts of characters come after it. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;

    localparam int COLS  = txcon_pkg::SCREEN_COLUMNS_DEF;
    localparam int ROWS  = txcon_pkg::SCREEN_ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    // One result transaction, laid out as m_tdata[38:0]
    typedef struct packed {
        logic [7:0]                   attr;
        logic [7:0]                   chr;
        logic [txcon_pkg::OFF_W-1:0]  offset;
        logic [txcon_pkg::PROW_W-1:0] row;
        logic [txcon_pkg::PCOL_W-1:0] col;
    } cursor_report_t;

    // One row of the directed table
    typedef struct {
        logic [txcon_pkg::OPC_W-1:0]  op;
        logic [txcon_pkg::CHAR_W-1:0] chr;
        logic [txcon_pkg::PCOL_W-1:0] col;
        logic [txcon_pkg::PROW_W-1:0] row;
        bit                           fixed;
        cursor_report_t               want;
    } step_row_t;

    localparam int NUM_STEPS = 26;

    logic                           clk;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [txcon_pkg::IN_W-1:0]     s_tdata  = '0;
    logic [txcon_pkg::OPC_W-1:0]    s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [txcon_pkg::OUT_W-1:0]    m_tdata;

    // Model state: screen image and cursor
    logic [txcon_pkg::CELL_W-1:0]   screen_img [0:CELLS-1];
    int                             cur_c;
    int                             cur_r;

    cursor_report_t                 cursor_reports_q [$];
    int                             mismatch_count = 0;
    bit                             no_idle        = 1'b0;

    text_console_cursor_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop for a hung run
    initial
    begin
        #40000000;
        $display("Mismatches found");
        $finish;
    end

    // Blank the whole model screen
    task automatic blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = txcon_pkg::BLANK_CELL;
    endtask

    // Advance the model cursor to the next line, scrolling past the bottom
    task automatic model_next_line();
        cur_c = 0;
        cur_r++;
        if (cur_r >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLS; i++)
                screen_img[i] = screen_img[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++)
                screen_img[i] = txcon_pkg::BLANK_CELL;
            cur_r = ROWS - 1;
        end
    endtask

    // Apply one operation to the model and build the expected result
    task automatic apply_console_op(input logic [txcon_pkg::OPC_W-1:0] op,
                                    input logic [txcon_pkg::CHAR_W-1:0] chr,
                                    input logic [txcon_pkg::PCOL_W-1:0] col,
                                    input logic [txcon_pkg::PROW_W-1:0] row,
                                    output cursor_report_t rep);
        int                           cc;
        int                           cr;
        logic [txcon_pkg::CELL_W-1:0] rd_cell;
        cc      = (int'(col) >= COLS) ? COLS - 1 : int'(col);
        cr      = (int'(row) >= ROWS) ? ROWS - 1 : int'(row);
        rd_cell = '0;
        case (op)
            txcon_pkg::OP_PUT:
            begin
                if (chr == txcon_pkg::CH_BACKSPACE)
                begin
                    if (cur_c != 0 || cur_r != 0)
                    begin
                        if (cur_c > 0)
                            cur_c--;
                        else
                        begin
                            cur_r--;
                            cur_c = COLS - 1;
                        end
                        screen_img[cur_r * COLS + cur_c] = txcon_pkg::BLANK_CELL;
                    end
                end
                else if (chr == txcon_pkg::CH_NEWLINE)
                    model_next_line();
                else
                begin
                    screen_img[cur_r * COLS + cur_c] = {txcon_pkg::TEXT_ATTR, chr};
                    cur_c++;
                    if (cur_c >= COLS)
                        model_next_line();
                end
            end
            txcon_pkg::OP_SETC:
            begin
                cur_c = cc;
                cur_r = cr;
            end
            txcon_pkg::OP_CLEAR:
            begin
                blank_screen();
                cur_c = 0;
                cur_r = 0;
            end
            default:
                rd_cell = screen_img[cr * COLS + cc];
        endcase
        rep.col    = cur_c[txcon_pkg::PCOL_W-1:0];
        rep.row    = cur_r[txcon_pkg::PROW_W-1:0];
        rep.offset = txcon_pkg::OFF_W'(cur_r * COLS + cur_c);
        rep.chr    = rd_cell[7:0];
        rep.attr   = rd_cell[15:8];
    endtask

    // Send one transaction; called at a rising edge, returns at the accepting edge
    task automatic drive_op(input logic [txcon_pkg::OPC_W-1:0] op,
                            input logic [txcon_pkg::CHAR_W-1:0] chr,
                            input logic [txcon_pkg::PCOL_W-1:0] col,
                            input logic [txcon_pkg::PROW_W-1:0] row,
                            input bit fixed, input cursor_report_t fixed_rep);
        cursor_report_t rep;
        if (!no_idle && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (!no_idle && $urandom_range(99) < 32);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, row, col, chr};
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        apply_console_op(op, chr, col, row, rep);
        cursor_reports_q.push_back(fixed ? fixed_rep : rep);
    endtask

    // Print one mismatch and count it
    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Random backpressure on the result side
    always @(posedge clk)
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);

    // Check each result transaction; data is stable from here to the next edge
    always @(negedge clk)
    begin : check_results
        cursor_report_t got;
        cursor_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[38:0];
            if (cursor_reports_q.size() == 0)
                flag_mismatch("unexpected result, offset", int'(got.offset), -1);
            else
            begin
                want = cursor_reports_q.pop_front();
                if (got.col != want.col)
                    flag_mismatch("cursor_col", int'(got.col), int'(want.col));
                if (got.row != want.row)
                    flag_mismatch("cursor_row", int'(got.row), int'(want.row));
                if (got.offset != want.offset)
                    flag_mismatch("cursor_offset", int'(got.offset), int'(want.offset));
                if (got.chr != want.chr)
                    flag_mismatch("cell_char", int'(got.chr), int'(want.chr));
                if (got.attr != want.attr)
                    flag_mismatch("cell_attr", int'(got.attr), int'(want.attr));
            end
        end
    end

    function automatic step_row_t step_row(input logic [1:0] op, input int chr, input int col,
                                           input int row, input bit fixed, input int ecol,
                                           input int erow, input int eoff, input int echr,
                                           input int eattr);
        step_row_t s;
        s.op          = op;
        s.chr         = chr[7:0];
        s.col         = col[6:0];
        s.row         = row[4:0];
        s.fixed       = fixed;
        s.want.col    = ecol[6:0];
        s.want.row    = erow[4:0];
        s.want.offset = eoff[10:0];
        s.want.chr    = echr[7:0];
        s.want.attr   = eattr[7:0];
        return s;
    endfunction

    // Stimulus
    initial
    begin
        step_row_t                    steps [0:NUM_STEPS-1];
        cursor_report_t               none;
        int                           item_count;
        int                           burst_left;
        int                           sel;
        logic [txcon_pkg::OPC_W-1:0]  op;
        logic [txcon_pkg::CHAR_W-1:0] chr;
        logic [txcon_pkg::PCOL_W-1:0] col;
        logic [txcon_pkg::PROW_W-1:0] row;

        none = '0;
        blank_screen();
        cur_c = 0;
        cur_r = 0;

        // Directed table: op, char, col, row, fixed, col, row, offset, char, attr
        steps[0]  = step_row(txcon_pkg::OP_READ,  0,    0,   0,   1, 0,  0,  0,    'h20, 'h0F);
        steps[1]  = step_row(txcon_pkg::OP_PUT,   8,    0,   0,   1, 0,  0,  0,    0,    0);
        steps[2]  = step_row(txcon_pkg::OP_SETC,  0,    127, 31,  1, 79, 24, 1999, 0,    0);
        steps[3]  = step_row(txcon_pkg::OP_READ,  0,    127, 31,  1, 79, 24, 1999, 'h20, 'h0F);
        steps[4]  = step_row(txcon_pkg::OP_PUT,   'h41, 0,   0,   1, 0,  24, 1920, 0,    0);
        steps[5]  = step_row(txcon_pkg::OP_READ,  0,    79,  23,  1, 0,  24, 1920, 'h41, 'h0F);
        steps[6]  = step_row(txcon_pkg::OP_PUT,   8,    0,   0,   1, 79, 23, 1919, 0,    0);
        steps[7]  = step_row(txcon_pkg::OP_READ,  0,    79,  23,  1, 79, 23, 1919, 'h20, 'h0F);
        steps[8]  = step_row(txcon_pkg::OP_PUT,   10,   0,   0,   1, 0,  24, 1920, 0,    0);
        steps[9]  = step_row(txcon_pkg::OP_PUT,   10,   0,   0,   1, 0,  24, 1920, 0,    0);
        steps[10] = step_row(txcon_pkg::OP_SETC,  0,    80,  25,  1, 79, 24, 1999, 0,    0);
        steps[11] = step_row(txcon_pkg::OP_PUT,   255,  0,   0,   1, 0,  24, 1920, 0,    0);
        steps[12] = step_row(txcon_pkg::OP_PUT,   0,    0,   0,   0, 0,  0,  0,    0,    0);
        steps[13] = step_row(txcon_pkg::OP_READ,  0,    0,   24,  0, 0,  0,  0,    0,    0);
        steps[14] = step_row(txcon_pkg::OP_READ,  0,    79,  23,  0, 0,  0,  0,    0,    0);
        steps[15] = step_row(txcon_pkg::OP_SETC,  0,    0,   0,   1, 0,  0,  0,    0,    0);
        steps[16] = step_row(txcon_pkg::OP_PUT,   10,   0,   0,   0, 0,  0,  0,    0,    0);
        steps[17] = step_row(txcon_pkg::OP_PUT,   'h7F, 127, 31,  0, 0,  0,  0,    0,    0);
        steps[18] = step_row(txcon_pkg::OP_PUT,   8,    0,   0,   0, 0,  0,  0,    0,    0);
        steps[19] = step_row(txcon_pkg::OP_SETC,  0,    79,  0,   0, 0,  0,  0,    0,    0);
        steps[20] = step_row(txcon_pkg::OP_PUT,   'h5A, 0,   0,   0, 0,  0,  0,    0,    0);
        steps[21] = step_row(txcon_pkg::OP_READ,  0,    0,   31,  0, 0,  0,  0,    0,    0);
        steps[22] = step_row(txcon_pkg::OP_CLEAR, 255,  127, 31,  1, 0,  0,  0,    0,    0);
        steps[23] = step_row(txcon_pkg::OP_READ,  0,    79,  23,  1, 0,  0,  0,    'h20, 'h0F);
        steps[24] = step_row(txcon_pkg::OP_SETC,  0,    0,   24,  1, 0,  24, 1920, 0,    0);
        steps[25] = step_row(txcon_pkg::OP_PUT,   8,    0,   0,   1, 79, 23, 1919, 0,    0);

        // Hold reset, then release at an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_STEPS; i++)
            drive_op(steps[i].op, steps[i].chr, steps[i].col, steps[i].row,
                     steps[i].fixed, steps[i].want);

        // Hold off until every outstanding result has drained
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (cursor_reports_q.size() != 0);

        // Random part: cursor moves followed by bursts of characters and reads
        item_count = 0;
        burst_left = 0;
        while (item_count < 300)
        begin
            no_idle = (item_count >= 120 && item_count < 180);
            if (burst_left == 0)
            begin
                if ($urandom_range(99) < 85)
                begin
                    sel = $urandom_range(99);
                    col = txcon_pkg::PCOL_W'((sel < 30) ? $urandom_range(79, 70) :
                          (sel < 40) ? $urandom_range(127, 80) : $urandom_range(79, 0));
                    sel = $urandom_range(99);
                    row = txcon_pkg::PROW_W'((sel < 40) ? $urandom_range(24, 22) :
                          (sel < 50) ? $urandom_range(31, 25) : $urandom_range(24, 0));
                    drive_op(txcon_pkg::OP_SETC, txcon_pkg::CHAR_W'($urandom_range(255)),
                             col, row, 1'b0, none);
                    burst_left = $urandom_range(12, 1);
                end
                else
                begin
                    op = txcon_pkg::OPC_W'($urandom_range(3));
                    // keep full-screen clears rare
                    if (op == txcon_pkg::OP_CLEAR && $urandom_range(7) != 0)
                        op = txcon_pkg::OP_READ;
                    drive_op(op, txcon_pkg::CHAR_W'($urandom_range(255)),
                             txcon_pkg::PCOL_W'($urandom_range(127)),
                             txcon_pkg::PROW_W'($urandom_range(31)), 1'b0, none);
                end
            end
            else
            begin
                burst_left--;
                if ($urandom_range(99) < 75)
                begin
                    sel = $urandom_range(99);
                    chr = (sel < 10) ? txcon_pkg::CH_BACKSPACE :
                          (sel < 20) ? txcon_pkg::CH_NEWLINE :
                          txcon_pkg::CHAR_W'($urandom_range(255));
                    drive_op(txcon_pkg::OP_PUT, chr,
                             txcon_pkg::PCOL_W'($urandom_range(127)),
                             txcon_pkg::PROW_W'($urandom_range(31)), 1'b0, none);
                end
                else
                    drive_op(txcon_pkg::OP_READ, txcon_pkg::CHAR_W'($urandom_range(255)),
                             txcon_pkg::PCOL_W'($urandom_range(127)),
                             txcon_pkg::PROW_W'($urandom_range(31)), 1'b0, none);
            end
            item_count++;
        end
        no_idle = 1'b0;

        // Drain, then allow for a trailing scroll or clear
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (cursor_reports_q.size() != 0);
        repeat (CELLS + 100) @(posedge clk);

        if (mismatch_count == 0 && cursor_reports_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/txcon_pkg.sv
design/txcon_ram.sv
design/text_console_cursor_engine.sv
dv/text_console_cursor_engine_tb.sv
